/* sv/hbs_pkg.sv */
// Shared constants, control types and the lerp function of the heightfield sampler.
package hbs_pkg;

    localparam int CFG_SIDE_W = 9;
    localparam int STEP_W     = 16;
    localparam int COORD_W    = 16;
    localparam int LEVEL_W    = 16;
    localparam int FRAC_W     = 8;
    localparam int CELL_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int GRID_W     = COORD_W + STEP_W - FRAC_W;
    localparam int IN_DATA_W  = 2 * CELL_W + LEVEL_W + 2 * COORD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_STEP = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic              query;
        logic              bad;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fz;
        logic              x0p;
        logic              x1p;
        logic              z0p;
        logic              z1p;
    } t_query_ctl;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               bad;
    } t_result;

    function automatic logic [LEVEL_W-1:0] lerp(
        input logic [LEVEL_W-1:0] a,
        input logic [LEVEL_W-1:0] b,
        input logic [FRAC_W-1:0]  f
    );
        logic [LEVEL_W+FRAC_W:0]   pa;
        logic [LEVEL_W+FRAC_W:0]   pb;
        logic [LEVEL_W+FRAC_W+1:0] s;
        pa = (LEVEL_W + FRAC_W + 1)'(a) * (LEVEL_W + FRAC_W + 1)'(9'd256 - 9'(f));
        pb = (LEVEL_W + FRAC_W + 1)'(b) * (LEVEL_W + FRAC_W + 1)'(f);
        s  = (LEVEL_W + FRAC_W + 2)'(pa) + (LEVEL_W + FRAC_W + 2)'(pb)
           + (LEVEL_W + FRAC_W + 2)'(128);
        return s[LEVEL_W+FRAC_W-1:FRAC_W];
    endfunction

endpackage

/* sv/hbs_grid_map.sv */
// Scales query positions to grid coordinates and forms the bank addresses of both item kinds.
module hbs_grid_map
    import hbs_pkg::*;
#(
    parameter int MAX_SIDE   = 256,
    parameter int LEVEL_BITS = 16
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_adv,
    input  logic                                            i_valid,
    input  logic                                            i_cmd,
    input  logic [CELL_W-1:0]                               i_cell_column,
    input  logic [CELL_W-1:0]                               i_cell_row,
    input  logic [LEVEL_W-1:0]                              i_cell_level,
    input  logic [COORD_W-1:0]                              i_query_x,
    input  logic [COORD_W-1:0]                              i_query_z,
    input  logic [CFG_SIDE_W-1:0]                           i_grid_width,
    input  logic [CFG_SIDE_W-1:0]                           i_grid_height,
    input  logic [STEP_W-1:0]                               i_inverse_step,
    output logic                                            o_valid,
    output t_query_ctl                                      o_ctl,
    output logic [3:0][$clog2(((MAX_SIDE+1)/2)*((MAX_SIDE+1)/2))-1:0] o_rd_addr,
    output logic                                            o_wr_en,
    output logic [1:0]                                      o_wr_bank,
    output logic [$clog2(((MAX_SIDE+1)/2)*((MAX_SIDE+1)/2))-1:0] o_wr_addr,
    output logic [((LEVEL_BITS < LEVEL_W) ? LEVEL_BITS : LEVEL_W)-1:0] o_wr_data
);

    localparam int HALF = (MAX_SIDE + 1) / 2;
    localparam int AW   = $clog2(HALF * HALF);
    localparam int HW   = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int IW   = $clog2(MAX_SIDE);
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int SB   = (LEVEL_BITS < LEVEL_W) ? LEVEL_BITS : LEVEL_W;

    function automatic logic [SW-1:0] clamp_side(input logic [CFG_SIDE_W-1:0] v);
        logic [31:0] wv;
        wv = 32'(v);
        if (wv < 32'd2) begin
            return SW'(2);
        end else if (wv > 32'(MAX_SIDE)) begin
            return SW'(MAX_SIDE);
        end
        return SW'(wv);
    endfunction

    logic                r1_valid;
    logic                r1_cmd;
    logic [GRID_W-1:0]   r1_gx;
    logic [GRID_W-1:0]   r1_gz;
    logic [CELL_W-1:0]   r1_col;
    logic [CELL_W-1:0]   r1_row;
    logic [SB-1:0]       r1_level;

    logic [GRID_W-1:0]   n1_gx;
    logic [GRID_W-1:0]   n1_gz;

    assign n1_gx = GRID_W'((32'(i_query_x) * 32'(i_inverse_step)) >> FRAC_W);
    assign n1_gz = GRID_W'((32'(i_query_z) * 32'(i_inverse_step)) >> FRAC_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_cmd   <= i_cmd;
            r1_gx    <= n1_gx;
            r1_gz    <= n1_gz;
            r1_col   <= i_cell_column;
            r1_row   <= i_cell_row;
            r1_level <= SB'(i_cell_level);
        end
    end

    logic [SW-1:0]             w_side_x;
    logic [SW-1:0]             w_side_z;
    logic [GRID_W-FRAC_W-1:0]  w_ip_x;
    logic [GRID_W-FRAC_W-1:0]  w_ip_z;
    logic                      w_bad_x;
    logic                      w_bad_z;
    logic [IW-1:0]             w_x0;
    logic [IW-1:0]             w_z0;
    logic                      w_xdup;
    logic                      w_zdup;
    logic [HW-1:0]             w_col_even;
    logic [HW-1:0]             w_col_odd;
    logic [HW-1:0]             w_row_even;
    logic [HW-1:0]             w_row_odd;
    logic                      w_load_ok;
    t_query_ctl                n2_ctl;
    logic [3:0][AW-1:0]        n2_rd_addr;

    always_comb begin
        w_side_x = clamp_side(i_grid_width);
        w_side_z = clamp_side(i_grid_height);
        w_ip_x   = r1_gx[GRID_W-1:FRAC_W];
        w_ip_z   = r1_gz[GRID_W-1:FRAC_W];
        w_bad_x  = 32'(w_ip_x) >= 32'(w_side_x);
        w_bad_z  = 32'(w_ip_z) >= 32'(w_side_z);
        w_x0     = w_bad_x ? IW'(w_side_x - SW'(1)) : IW'(w_ip_x);
        w_z0     = w_bad_z ? IW'(w_side_z - SW'(1)) : IW'(w_ip_z);
        w_xdup   = (32'(w_x0) + 32'd1) >= 32'(w_side_x);
        w_zdup   = (32'(w_z0) + 32'd1) >= 32'(w_side_z);

        w_col_even = HW'((32'(w_x0) + 32'd1) >> 1);
        w_col_odd  = HW'(32'(w_x0) >> 1);
        w_row_even = HW'((32'(w_z0) + 32'd1) >> 1);
        w_row_odd  = HW'(32'(w_z0) >> 1);

        n2_ctl.query = r1_cmd == CMD_QUERY;
        n2_ctl.bad   = w_bad_x | w_bad_z;
        n2_ctl.fx    = w_bad_x ? '0 : r1_gx[FRAC_W-1:0];
        n2_ctl.fz    = w_bad_z ? '0 : r1_gz[FRAC_W-1:0];
        n2_ctl.x0p   = w_x0[0];
        n2_ctl.x1p   = w_x0[0] ^ ~w_xdup;
        n2_ctl.z0p   = w_z0[0];
        n2_ctl.z1p   = w_z0[0] ^ ~w_zdup;

        for (int b = 0; b < 4; b++) begin
            n2_rd_addr[b] = AW'(32'(b[1] ? w_row_odd : w_row_even) * 32'(HALF)
                              + 32'(b[0] ? w_col_odd : w_col_even));
        end

        w_load_ok = (32'(r1_col) < 32'(MAX_SIDE)) && (32'(r1_row) < 32'(MAX_SIDE));
    end

    logic       r2_valid;
    logic       r2_wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r2_wr_en <= 1'b0;
        end else if (i_adv) begin
            r2_valid <= r1_valid;
            r2_wr_en <= r1_valid && (r1_cmd == CMD_LOAD) && w_load_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_ctl     <= n2_ctl;
            o_rd_addr <= n2_rd_addr;
            o_wr_bank <= {r1_row[0], r1_col[0]};
            o_wr_addr <= AW'(32'(r1_row >> 1) * 32'(HALF) + 32'(r1_col >> 1));
            o_wr_data <= r1_level;
        end
    end

    assign o_valid = r2_valid;
    assign o_wr_en = r2_wr_en;

endmodule

/* sv/hbs_level_store.sv */
// Height store split into four banks by row and column parity, one read and one write port each.
module hbs_level_store
    import hbs_pkg::*;
#(
    parameter int MAX_SIDE   = 256,
    parameter int LEVEL_BITS = 16
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_adv,
    input  logic                                            i_valid,
    input  t_query_ctl                                      i_ctl,
    input  logic [3:0][$clog2(((MAX_SIDE+1)/2)*((MAX_SIDE+1)/2))-1:0] i_rd_addr,
    input  logic                                            i_wr_en,
    input  logic [1:0]                                      i_wr_bank,
    input  logic [$clog2(((MAX_SIDE+1)/2)*((MAX_SIDE+1)/2))-1:0] i_wr_addr,
    input  logic [((LEVEL_BITS < LEVEL_W) ? LEVEL_BITS : LEVEL_W)-1:0] i_wr_data,
    output logic                                            o_valid,
    output t_query_ctl                                      o_ctl,
    output logic [3:0][((LEVEL_BITS < LEVEL_W) ? LEVEL_BITS : LEVEL_W)-1:0] o_rd_data
);

    localparam int HALF  = (MAX_SIDE + 1) / 2;
    localparam int DEPTH = HALF * HALF;
    localparam int AW    = $clog2(DEPTH);
    localparam int SB    = (LEVEL_BITS < LEVEL_W) ? LEVEL_BITS : LEVEL_W;

    logic r3_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_adv) begin
            r3_valid <= i_valid && i_ctl.query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_ctl <= i_ctl;
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [SB-1:0] mem [DEPTH];

        always_ff @(posedge i_clk) begin
            if (i_adv && i_wr_en && (i_wr_bank == 2'(b))) begin
                mem[i_wr_addr] <= i_wr_data;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                o_rd_data[b] <= mem[i_rd_addr[b]];
            end
        end
    end

    assign o_valid = r3_valid;

endmodule

/* sv/hbs_blend.sv */
// Picks the four corners from the banks, lerps along x, and lerps the two rows along z.
module hbs_blend
    import hbs_pkg::*;
#(
    parameter int LEVEL_BITS = 16
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_adv,
    input  logic                                            i_valid,
    input  t_query_ctl                                      i_ctl,
    input  logic [3:0][((LEVEL_BITS < LEVEL_W) ? LEVEL_BITS : LEVEL_W)-1:0] i_rd_data,
    output logic                                            o_valid,
    output t_result                                         o_result
);

    localparam int SB = (LEVEL_BITS < LEVEL_W) ? LEVEL_BITS : LEVEL_W;

    logic [SB-1:0]      w_v0;
    logic [SB-1:0]      w_v1;
    logic [SB-1:0]      w_v2;
    logic [SB-1:0]      w_v3;
    logic [LEVEL_W-1:0] n_bot;
    logic [LEVEL_W-1:0] n_top;

    always_comb begin
        w_v0  = i_rd_data[{i_ctl.z0p, i_ctl.x0p}];
        w_v1  = i_rd_data[{i_ctl.z1p, i_ctl.x0p}];
        w_v2  = i_rd_data[{i_ctl.z0p, i_ctl.x1p}];
        w_v3  = i_rd_data[{i_ctl.z1p, i_ctl.x1p}];
        n_bot = lerp(LEVEL_W'(w_v0), LEVEL_W'(w_v2), i_ctl.fx);
        n_top = lerp(LEVEL_W'(w_v1), LEVEL_W'(w_v3), i_ctl.fx);
    end

    logic               r4_valid;
    logic [LEVEL_W-1:0] r4_bot;
    logic [LEVEL_W-1:0] r4_top;
    logic [FRAC_W-1:0]  r4_fz;
    logic               r4_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_adv) begin
            r4_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_bot <= n_bot;
            r4_top <= n_top;
            r4_fz  <= i_ctl.fz;
            r4_bad <= i_ctl.bad;
        end
    end

    assign o_valid        = r4_valid;
    assign o_result.level = lerp(r4_bot, r4_top, r4_fz);
    assign o_result.bad   = r4_bad;

endmodule

/* sv/heightfield_bilinear_sampler.sv */
// Top level of the heightfield sampler: configuration registers, pipeline and output skid stage.
//
// The sampler takes one word per cycle while not stalled, loads and queries alike. A query's
// result passes five register stages (scaling multiply, grid mapping, store read, x lerps, z
// lerp). The first loads at the edge that accepts the word; the rest follow in that order, the
// last being the output register. The height store is four banks split by row and column parity,
// each with one read port, so all four corners of a query are read in the same cycle. The input
// only stalls once the output register and its skid stage are both full. The store holds
// nothing defined after reset: every cell a query can touch must be loaded first.
module heightfield_bilinear_sampler
    import hbs_pkg::*;
#(
    parameter int MAX_SIDE   = 256,
    parameter int LEVEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cell_column, cell_row, cell_level, query_x, query_z
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // sampled_level
    output logic [LEVEL_W-1:0]    m_axis_tdata,
    // out_of_grid
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [STEP_W-1:0]     i_cfg_data
);

    localparam int HALF = (MAX_SIDE + 1) / 2;
    localparam int AW   = $clog2(HALF * HALF);
    localparam int SB   = (LEVEL_BITS < LEVEL_W) ? LEVEL_BITS : LEVEL_W;

    logic [CFG_SIDE_W-1:0] r_grid_width;
    logic [CFG_SIDE_W-1:0] r_grid_height;
    logic [STEP_W-1:0]     r_inverse_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width   <= CFG_SIDE_W'(256);
            r_grid_height  <= CFG_SIDE_W'(256);
            r_inverse_step <= STEP_W'(256);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:   r_grid_width   <= i_cfg_data[CFG_SIDE_W-1:0];
                CFG_GRID_HEIGHT:  r_grid_height  <= i_cfg_data[CFG_SIDE_W-1:0];
                CFG_INVERSE_STEP: r_inverse_step <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic                  r_out_v;
    logic                  r_skid_v;
    t_result               r_out;
    t_result               r_skid;
    logic                  w_adv;

    assign w_adv         = !r_skid_v;
    assign s_axis_tready = w_adv;

    logic                  w_v2;
    t_query_ctl            w_ctl2;
    logic [3:0][AW-1:0]    w_rd_addr;
    logic                  w_wr_en;
    logic [1:0]            w_wr_bank;
    logic [AW-1:0]         w_wr_addr;
    logic [SB-1:0]         w_wr_data;

    hbs_grid_map #(
        .MAX_SIDE   (MAX_SIDE),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_grid_map (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_valid        (s_axis_tvalid),
        .i_cmd          (s_axis_tuser),
        .i_cell_column  (s_axis_tdata[CELL_W-1:0]),
        .i_cell_row     (s_axis_tdata[2*CELL_W-1:CELL_W]),
        .i_cell_level   (s_axis_tdata[2*CELL_W+LEVEL_W-1:2*CELL_W]),
        .i_query_x      (s_axis_tdata[2*CELL_W+LEVEL_W+COORD_W-1:2*CELL_W+LEVEL_W]),
        .i_query_z      (s_axis_tdata[IN_DATA_W-1:2*CELL_W+LEVEL_W+COORD_W]),
        .i_grid_width   (r_grid_width),
        .i_grid_height  (r_grid_height),
        .i_inverse_step (r_inverse_step),
        .o_valid        (w_v2),
        .o_ctl          (w_ctl2),
        .o_rd_addr      (w_rd_addr),
        .o_wr_en        (w_wr_en),
        .o_wr_bank      (w_wr_bank),
        .o_wr_addr      (w_wr_addr),
        .o_wr_data      (w_wr_data)
    );

    logic                  w_v3;
    t_query_ctl            w_ctl3;
    logic [3:0][SB-1:0]    w_rd_data;

    hbs_level_store #(
        .MAX_SIDE   (MAX_SIDE),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_level_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_valid   (w_v2),
        .i_ctl     (w_ctl2),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_bank (w_wr_bank),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_valid   (w_v3),
        .o_ctl     (w_ctl3),
        .o_rd_data (w_rd_data)
    );

    logic                  w_v4;
    t_result               w_result;

    hbs_blend #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_valid   (w_v3),
        .i_ctl     (w_ctl3),
        .i_rd_data (w_rd_data),
        .o_valid   (w_v4),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (m_axis_tready) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_v4) begin
            if (r_out_v && !m_axis_tready) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (m_axis_tready) begin
                r_out <= r_skid;
            end
        end else if (w_v4) begin
            if (r_out_v && !m_axis_tready) begin
                r_skid <= w_result;
            end else begin
                r_out <= w_result;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out.level;
    assign m_axis_tuser  = r_out.bad;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage holds a word while the output register is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !m_axis_tready) |=> (r_skid_v && $stable(r_skid)))
        else $error("skid stage word changed or was lost under backpressure");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_v4 && !r_out_v) |=> r_out_v)
        else $error("finished query did not reach the output register");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !m_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while output and skid stages are full");

endmodule
